### rtl/core/krt_pkg.sv
package krt_pkg;

    localparam int MAX_RESULTS = 64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_UPDATE = 2'd2,
        OP_DUMP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_DUP       = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_BAD_PRICE = 3'd4,
        STAT_EMPTY     = 3'd5
    } status_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic emit;
        logic dump_rd;
        logic dump_out;
    } krt_cmd_t;

    typedef struct packed {
        logic in_dump;
        logic empty;
        logic hit;
        logic miss;
        logic out_free;
        logic dump_last;
    } krt_stat_t;

endpackage

### rtl/core/krt_ctrl.sv
module krt_ctrl
    import krt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output krt_cmd_t  cmd,
    input  krt_stat_t st
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_EMIT = 5'b00100,
        S_DRD  = 5'b01000,
        S_DOUT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (!st.in_dump)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (st.empty)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_DRD;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.hit || st.miss)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DRD:
            begin
                cmd.dump_rd = 1'b1;
                state_next  = S_DOUT;
            end
            S_DOUT:
            begin
                if (st.out_free)
                begin
                    cmd.dump_out = 1'b1;
                    state_next   = st.dump_last ? S_IDLE : S_DRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/krt_dp.sv
module krt_dp
    import krt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] s_tuser,   // op
    input  logic [95:0] s_tdata,  // part_key, price_cents, amount
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [95:0] m_tdata,  // key_out, price_out, quantity_out
    output logic [2:0] m_tuser,   // status
    output logic       m_tlast,
    input  krt_cmd_t   cmd,
    output krt_stat_t  st
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMP_W = CNT_W + 7;

    logic [31:0] key_mem   [TABLE_DEPTH];
    logic [31:0] price_mem [TABLE_DEPTH];
    logic [31:0] qty_mem   [TABLE_DEPTH];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] ptr_reg;
    logic [CNT_W-1:0] ptr_next;
    logic             cmp_vld_reg;
    logic             cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             found_reg;
    logic             found_next;
    logic [IDX_W-1:0] found_idx_reg;
    logic [31:0]      found_price_reg;
    logic [31:0]      found_qty_reg;

    op_t         req_op_reg;
    logic [31:0] req_key_reg;
    logic [31:0] req_price_reg;
    logic [31:0] req_amount_reg;

    logic [31:0] rd_key_reg;
    logic [31:0] rd_price_reg;
    logic [31:0] rd_qty_reg;

    logic        out_vld_reg;
    logic        out_vld_next;
    status_t     out_status_reg;
    logic [31:0] out_key_reg;
    logic [31:0] out_price_reg;
    logic [31:0] out_qty_reg;
    logic        out_last_reg;

    logic             hit_now;
    logic             issue;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] dump_n;
    logic             full;
    logic [32:0]      qty_sum;
    logic [31:0]      qty_sat;
    status_t          res_status;
    logic [31:0]      res_key;
    logic [31:0]      res_price;
    logic [31:0]      res_qty;
    logic             ins_wr;
    logic             upd_wr;

    assign hit_now = cmp_vld_reg && (rd_key_reg == req_key_reg);
    assign issue   = cmd.scan && (ptr_reg < count_reg) && !hit_now;
    assign rd_en   = issue || cmd.dump_rd;
    assign rd_addr = ptr_reg[IDX_W-1:0];
    assign full    = (count_reg >= CNT_W'(TABLE_DEPTH));

    assign dump_n = (CMP_W'(count_reg) > CMP_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS)
                                                              : count_reg;

    assign qty_sum = {found_qty_reg[31], found_qty_reg} + {req_amount_reg[31], req_amount_reg};
    assign qty_sat = (qty_sum[32] != qty_sum[31])
                   ? (qty_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                   : qty_sum[31:0];

    assign st.in_dump   = (op_t'(s_tuser) == OP_DUMP);
    assign st.empty     = (count_reg == '0);
    assign st.hit       = hit_now;
    assign st.miss      = cmd.scan && !hit_now && !cmp_vld_reg && (ptr_reg >= count_reg);
    assign st.out_free  = !out_vld_reg || m_tready;
    assign st.dump_last = ((ptr_reg + CNT_W'(1)) == dump_n);

    always_comb
    begin
        res_status = STAT_OK;
        res_key    = req_key_reg;
        res_price  = 32'd0;
        res_qty    = 32'd0;
        ins_wr     = 1'b0;
        upd_wr     = 1'b0;
        unique case (req_op_reg)
            OP_INSERT:
            begin
                if (full)
                begin
                    res_status = STAT_FULL;
                end
                else if (found_reg)
                begin
                    res_status = STAT_DUP;
                end
                else if (req_price_reg[31])
                begin
                    res_status = STAT_BAD_PRICE;
                end
                else
                begin
                    res_price = req_price_reg;
                    res_qty   = req_amount_reg;
                    ins_wr    = 1'b1;
                end
            end
            OP_LOOKUP:
            begin
                if (found_reg)
                begin
                    res_price = found_price_reg;
                    res_qty   = found_qty_reg;
                end
                else
                begin
                    res_status = STAT_NOT_FOUND;
                end
            end
            OP_UPDATE:
            begin
                if (found_reg)
                begin
                    res_price = found_price_reg;
                    res_qty   = qty_sat;
                    upd_wr    = 1'b1;
                end
                else
                begin
                    res_status = STAT_NOT_FOUND;
                end
            end
            OP_DUMP:
            begin
                res_status = STAT_EMPTY;
                res_key    = 32'd0;
            end
            default:
            begin
                res_status = STAT_OK;
            end
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        cmp_vld_next = issue;
        found_next   = found_reg || hit_now;
        out_vld_next = out_vld_reg && !m_tready;
        if (cmd.load)
        begin
            ptr_next   = '0;
            found_next = 1'b0;
        end
        else if (issue || cmd.dump_out)
        begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
        if (cmd.emit && ins_wr)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.emit || cmd.dump_out)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ptr_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg   <= found_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_op_reg     <= op_t'(s_tuser);
            req_key_reg    <= s_tdata[31:0];
            req_price_reg  <= s_tdata[63:32];
            req_amount_reg <= s_tdata[95:64];
        end
        if (issue)
        begin
            cmp_idx_reg <= rd_addr;
        end
        if (hit_now)
        begin
            found_idx_reg   <= cmp_idx_reg;
            found_price_reg <= rd_price_reg;
            found_qty_reg   <= rd_qty_reg;
        end
        if (cmd.emit || cmd.dump_out)
        begin
            if (cmd.emit)
            begin
                out_status_reg <= res_status;
                out_key_reg    <= res_key;
                out_price_reg  <= res_price;
                out_qty_reg    <= res_qty;
                out_last_reg   <= 1'b1;
            end
            else
            begin
                out_status_reg <= STAT_OK;
                out_key_reg    <= rd_key_reg;
                out_price_reg  <= rd_price_reg;
                out_qty_reg    <= rd_qty_reg;
                out_last_reg   <= st.dump_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_price_reg <= price_mem[rd_addr];
            rd_qty_reg   <= qty_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit && ins_wr)
        begin
            key_mem[count_reg[IDX_W-1:0]]   <= req_key_reg;
            price_mem[count_reg[IDX_W-1:0]] <= req_price_reg;
        end
        if (cmd.emit && (ins_wr || upd_wr))
        begin
            qty_mem[ins_wr ? count_reg[IDX_W-1:0] : found_idx_reg] <= res_qty;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_qty_reg, out_price_reg, out_key_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !m_tready) |-> !(cmd.emit || cmd.dump_out))
        else $error("stalled result overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dump_out |-> (ptr_reg < dump_n))
        else $error("dump ran past the stored entries");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && ins_wr) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted insert did not grow the table");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (req_op_reg != OP_INSERT)) |-> !ins_wr)
        else $error("table write outside an insert");

endmodule

### rtl/core/keyed_record_table.sv
// Record table with linear key search, kept in insertion order.
//
// Input channel s_*: s_tuser carries the operation (insert, lookup, update,
// dump); s_tdata carries key, price and amount. One operation is in work at a
// time; s_tready is high only while the table is idle.
// Output channel m_*: m_tuser carries the status, m_tdata the reported key,
// price and quantity, m_tlast marks the final transfer of an operation.
// Results sit in an output register, so the next operation is accepted while
// the previous result still waits for m_tready.
//
// Insert, lookup and update scan the key store at one entry per cycle through
// the registered read port. Dump alternates between reading one entry and
// sending it, and sends up to 64 transfers.
//
// Reset empties the table at once; the stores are not cleared. While m_tready
// is low the current result holds and the controller waits before the next.
module keyed_record_table
    import krt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // op
    input  logic [95:0] s_tdata,   // part_key, price_cents, amount
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // key_out, price_out, quantity_out
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast
);

    krt_cmd_t  cmd;
    krt_stat_t st;

    krt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .st       (st)
    );

    krt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench
    import krt_pkg::*;
();

    localparam int TABLE_DEPTH = 64;

    typedef struct {
        status_t     status;
        logic [31:0] key;
        logic [31:0] price;
        logic [31:0] quantity;
        logic        last;
    } record_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = OP_INSERT;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    logic [31:0] table_key [TABLE_DEPTH];
    logic [31:0] table_price [TABLE_DEPTH];
    logic [31:0] table_quantity [TABLE_DEPTH];
    int          table_count = 0;

    record_result_t pending_results[$];
    record_result_t oldest_result;

    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int dumps_sent = 0;
    int burst_left = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_stall_left = 0;

    keyed_record_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] expected,
                                   input logic [31:0] actual);
        errors++;
        $display("mismatch at %0t ns: %s expected %h got %h", $time, what, expected,
                 actual);
    endtask

    function automatic int find_entry(input logic [31:0] key);
        for (int i = 0; i < table_count; i++)
            if (table_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic void push_result(input status_t status, input logic [31:0] key,
                                        input logic [31:0] price,
                                        input logic [31:0] quantity, input logic last);
        record_result_t r;
        r.status = status;
        r.key = key;
        r.price = price;
        r.quantity = quantity;
        r.last = last;
        pending_results.push_back(r);
    endfunction

    function automatic void apply_table_op(input op_t op, input logic [31:0] key,
                                           input logic [31:0] price,
                                           input logic [31:0] amount);
        int                 hit;
        int                 n;
        logic signed [32:0] sum;
        hit = find_entry(key);
        case (op) inside
            OP_INSERT:
            begin
                if (table_count >= TABLE_DEPTH)
                    push_result(STAT_FULL, key, '0, '0, 1'b1);
                else if (hit >= 0)
                    push_result(STAT_DUP, key, '0, '0, 1'b1);
                else if (price[31])
                    push_result(STAT_BAD_PRICE, key, '0, '0, 1'b1);
                else
                begin
                    table_key[table_count] = key;
                    table_price[table_count] = price;
                    table_quantity[table_count] = amount;
                    table_count++;
                    push_result(STAT_OK, key, price, amount, 1'b1);
                end
            end
            OP_LOOKUP, OP_UPDATE:
            begin
                if (hit < 0)
                    push_result(STAT_NOT_FOUND, key, '0, '0, 1'b1);
                else
                begin
                    if (op == OP_UPDATE)
                    begin
                        sum = $signed({table_quantity[hit][31], table_quantity[hit]})
                              + $signed({amount[31], amount});
                        if (sum > 33'sh0_7FFF_FFFF)
                            table_quantity[hit] = 32'h7FFF_FFFF;
                        else if (sum < -33'sh0_8000_0000)
                            table_quantity[hit] = 32'h8000_0000;
                        else
                            table_quantity[hit] = sum[31:0];
                    end
                    push_result(STAT_OK, key, table_price[hit], table_quantity[hit], 1'b1);
                end
            end
            default:
            begin
                n = (table_count > MAX_RESULTS) ? MAX_RESULTS : table_count;
                if (n == 0)
                    push_result(STAT_EMPTY, '0, '0, '0, 1'b1);
                for (int i = 0; i < n; i++)
                    push_result(STAT_OK, table_key[i], table_price[i], table_quantity[i],
                                i == n - 1);
            end
        endcase
    endfunction

    task automatic send_op(input op_t op, input logic [31:0] key, input logic [31:0] price,
                           input logic [31:0] amount);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            s_tdata <= {$urandom, $urandom, $urandom};
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {amount, price, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_table_op(op, key, price, amount);
        items_sent++;
        if (op == OP_DUMP)
            dumps_sent++;
    endtask

    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        if (sel <= 5 && table_count > 0)
            return table_key[$urandom_range(0, table_count - 1)];
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_price();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 3)
            return $urandom | 32'h8000_0000;
        if (sel == 3)
            return 32'h7FFF_FFFF;
        if (sel == 4)
            return 32'h0000_0000;
        return $urandom & 32'h7FFF_FFFF;
    endfunction

    function automatic logic [31:0] pick_amount();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        if (sel < 5)
            return $urandom_range(0, 200) - 100;
        return $urandom;
    endfunction

    task automatic send_random_op(input int dump_weight);
        int  sel;
        op_t op;
        sel = $urandom_range(0, 99);
        if (sel < dump_weight)
            op = OP_DUMP;
        else if (sel < 40)
            op = OP_INSERT;
        else if (sel < 65)
            op = OP_LOOKUP;
        else
            op = OP_UPDATE;
        send_op(op, pick_key(), pick_price(), pick_amount());
    endtask

    task automatic test_empty_table();
        send_op(OP_DUMP, $urandom, $urandom, $urandom);
        send_op(OP_LOOKUP, 32'h0000_0000, 32'h0, 32'h0);
        send_op(OP_UPDATE, 32'h0000_0005, 32'hFFFF_FFFF, 32'h0000_0001);
    endtask

    task automatic test_insert_rules();
        send_op(OP_INSERT, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
        send_op(OP_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_op(OP_INSERT, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001);
        send_op(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0002);
        send_op(OP_INSERT, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 32'h8000_0000, 32'h0000_0005, 32'h0000_0003);
        send_op(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0004);
        send_op(OP_LOOKUP, 32'h8000_0000, $urandom, $urandom);
        send_op(OP_LOOKUP, 32'h7FFF_FFFF, $urandom, $urandom);
        send_op(OP_LOOKUP, 32'h0000_0000, $urandom, $urandom);
        send_op(OP_LOOKUP, 32'hFFFF_FFFF, $urandom, $urandom);
    endtask

    task automatic test_update_saturation();
        send_op(OP_UPDATE, 32'h7FFF_FFFF, $urandom, 32'h0000_0001);
        send_op(OP_UPDATE, 32'h8000_0000, $urandom, 32'hFFFF_FFFF);
        send_op(OP_UPDATE, 32'h7FFF_FFFF, $urandom, 32'h8000_0000);
        send_op(OP_UPDATE, 32'h8000_0000, $urandom, 32'h7FFF_FFFF);
        send_op(OP_UPDATE, 32'h0000_0000, $urandom, 32'h0000_0000);
        send_op(OP_UPDATE, 32'h1234_5678, $urandom, 32'h0000_0010);
        send_op(OP_DUMP, $urandom, $urandom, $urandom);
    endtask

    task automatic test_random_partial();
        repeat (150) send_random_op(4);
    endtask

    task automatic test_fill_table();
        while (table_count < TABLE_DEPTH)
            send_op(OP_INSERT, $urandom, $urandom & 32'h7FFF_FFFF, $urandom);
        send_op(OP_INSERT, table_key[0], 32'hFFFF_FFFF, $urandom);
        send_op(OP_INSERT, $urandom, $urandom & 32'h7FFF_FFFF, $urandom);
        send_op(OP_LOOKUP, table_key[TABLE_DEPTH - 1], $urandom, $urandom);
        send_op(OP_DUMP, $urandom, $urandom, $urandom);
    endtask

    task automatic test_random_full();
        repeat (180) send_random_op(3);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, key", 32'h0, m_tdata[31:0]);
            else
            begin
                oldest_result = pending_results.pop_front();
                results_checked++;
                if (m_tuser != oldest_result.status)
                    report_mismatch("status", 32'(oldest_result.status), 32'(m_tuser));
                if (m_tdata[31:0] != oldest_result.key)
                    report_mismatch("key_out", oldest_result.key, m_tdata[31:0]);
                if (m_tdata[63:32] != oldest_result.price)
                    report_mismatch("price_out", oldest_result.price, m_tdata[63:32]);
                if (m_tdata[95:64] != oldest_result.quantity)
                    report_mismatch("quantity_out", oldest_result.quantity, m_tdata[95:64]);
                if (m_tlast != oldest_result.last)
                    report_mismatch("last", 32'(oldest_result.last), 32'(m_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(32, 256);
        end
        else
            rx_mode_left--;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (rx_stall_left == 0)
                begin
                    m_tready <= 1'b1;
                    rx_stall_left = $urandom_range(0, 12);
                end
                else
                begin
                    m_tready <= 1'b0;
                    rx_stall_left--;
                end
            end
        endcase
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_insert_rules();
        test_update_saturation();
        test_random_partial();
        test_fill_table();
        test_random_full();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("%0d operations sent (%0d dumps), %0d result transfers checked, %0d mismatches",
                 items_sent, dumps_sent, results_checked, errors);
        $display("table filled to %0d of %0d entries", table_count, TABLE_DEPTH);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
